// File: hdl/scatter_elements_address_gen_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scatter-elements address generator
// Short wrappers for clocked implication checks with synchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef SCATTER_ELEMENTS_ADDRESS_GEN_DEFINES_SVH
`define SCATTER_ELEMENTS_ADDRESS_GEN_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SEAG_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define SEAG_ASSERT_NXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hdl/seag_pkg.sv
// ----------------------------------------------------------------------------
// seag_pkg
// Shared types, register codes and helpers for the scatter address generator.
// ----------------------------------------------------------------------------
package seag_pkg;

   // Fixed field widths
   localparam int CFG_W      = 64;
   localparam int IDX_W      = 17;
   localparam int WORD_W     = 32;
   localparam int ADDR_OUT_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int RANK_CFG_W = 3;
   localparam int AXIS_W     = 3;
   localparam int RANK_W     = 4;
   localparam int MAX_DIM_W  = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANK        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_DIMS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_DIMS = 2'd3;

   // Register reset values
   localparam logic [RANK_CFG_W-1:0] RANK_RESET = 3'd1;
   localparam logic [AXIS_W-1:0]     AXIS_RESET = 3'd0;
   localparam logic [CFG_W-1:0]      DIMS_RESET = 64'h0001_0001_0001_0001;

   // Stride builder states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_STEP,
      ST_IDLE
   } stride_state_type;

   // Effective geometry handed from the register block to the datapath
   typedef struct packed {
      logic                busy;
      logic [RANK_W-1:0]   rank;
      logic [AXIS_W-1:0]   axis;
   } geom_type;

   // Extract one packed dimension size; fields beyond bit 63 read as zero
   function automatic logic [MAX_DIM_W-1:0] dim_at(input logic [CFG_W-1:0] packed_dims,
                                                  input int unsigned shift);
      logic [CFG_W-1:0] shifted;
      shifted = '0;
      if (shift < CFG_W) begin
         shifted = packed_dims >> shift;
      end
      return shifted[MAX_DIM_W-1:0];
   endfunction

endpackage

// File: hdl/seag_cfg_regs.sv
// ----------------------------------------------------------------------------
// seag_cfg_regs
// Configuration registers, effective rank and axis, and a stride builder that
// produces one row-major stride per cycle after reset and after each write.
// ----------------------------------------------------------------------------
module seag_cfg_regs
   import seag_pkg::*;
#(
   parameter int MAX_RANK  = 4,
   parameter int DIM_BITS  = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output geom_type             geom,
   output logic [CFG_W-1:0]     data_dims,
   output logic [CFG_W-1:0]     update_dims,
   output logic [ADDR_BITS-1:0] stride [MAX_RANK]
);

   localparam int KW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

   logic [RANK_CFG_W-1:0] rank_ff;
   logic [AXIS_W-1:0]     axis_ff;
   logic [CFG_W-1:0]      data_dims_ff;
   logic [CFG_W-1:0]      update_dims_ff;

   logic [RANK_W-1:0]     rank_eff;
   logic [RANK_W-1:0]     rank_m1;
   logic signed [5:0]     axis_s;
   logic signed [5:0]     rank_s;

   logic [MAX_DIM_W-1:0]  dfield [MAX_RANK];
   logic [DIM_BITS-1:0]   dsize  [MAX_RANK];

   stride_state_type      state_ff;
   stride_state_type      state_in;
   logic                  do_load;
   logic                  do_step;

   logic [KW-1:0]         k_ff;
   logic [KW-1:0]         k_in;
   logic [ADDR_BITS-1:0]  prod_ff;
   logic [ADDR_BITS-1:0]  prod_in;
   logic [DIM_BITS+ADDR_BITS-1:0] prod_full;
   logic [ADDR_BITS-1:0]  stride_ff [MAX_RANK];
   logic [ADDR_BITS-1:0]  stride_in [MAX_RANK];

   // Capture register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff        <= RANK_RESET;
         axis_ff        <= AXIS_RESET;
         data_dims_ff   <= DIMS_RESET;
         update_dims_ff <= DIMS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RANK:        rank_ff        <= csr_wdata[RANK_CFG_W-1:0];
            CSR_AXIS:        axis_ff        <= csr_wdata[AXIS_W-1:0];
            CSR_DATA_DIMS:   data_dims_ff   <= csr_wdata;
            CSR_UPDATE_DIMS: update_dims_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp rank to 1..MAX_RANK, wrap and clamp the axis
   always_comb begin
      if (rank_ff == '0) begin
         rank_eff = RANK_W'(1);
      end else if ({1'b0, rank_ff} > RANK_W'(MAX_RANK)) begin
         rank_eff = RANK_W'(MAX_RANK);
      end else begin
         rank_eff = {1'b0, rank_ff};
      end
      rank_m1 = rank_eff - RANK_W'(1);
      rank_s  = $signed({2'b00, rank_eff});
      axis_s  = $signed({{3{axis_ff[AXIS_W-1]}}, axis_ff});
      if (axis_s < 6'sd0) begin
         axis_s = axis_s + rank_s;
      end
      if (axis_s < 6'sd0) begin
         axis_s = 6'sd0;
      end
      if (axis_s >= rank_s) begin
         axis_s = rank_s - 6'sd1;
      end
   end

   // Unpack data shape sizes
   for (genvar g = 0; g < MAX_RANK; g++) begin : g_dsize
      assign dfield[g] = dim_at(data_dims_ff, (MAX_RANK - 1 - g) * DIM_BITS);
      assign dsize[g]  = dfield[g][DIM_BITS-1:0];
   end

   // Next state: reload on every write, then one step for each stride outside the innermost
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: state_in = (rank_eff == RANK_W'(1)) ? ST_IDLE : ST_STEP;
         ST_STEP: state_in = (k_ff == KW'(1)) ? ST_IDLE : ST_STEP;
         ST_IDLE: state_in = ST_IDLE;
         default: state_in = ST_LOAD;
      endcase
      if (csr_write_enable) begin
         state_in = ST_LOAD;
      end
   end

   // Builder controls
   always_comb begin
      do_load = 1'b0;
      do_step = 1'b0;
      unique case (state_ff)
         ST_LOAD: do_load = 1'b1;
         ST_STEP: do_step = 1'b1;
         ST_IDLE: ;
         default: ;
      endcase
   end

   // One multiply per step: stride[k-1] = size[k] * stride[k]
   assign prod_full = {{ADDR_BITS{1'b0}}, dsize[k_ff]} * {{DIM_BITS{1'b0}}, prod_ff};
   assign prod_in   = prod_full[ADDR_BITS-1:0];

   always_comb begin
      stride_in = stride_ff;
      k_in      = k_ff;
      if (do_load) begin
         for (int i = 0; i < MAX_RANK; i++) begin
            stride_in[i] = (RANK_W'(i) == rank_m1) ? ADDR_BITS'(1) : '0;
         end
         k_in = rank_m1[KW-1:0];
      end else if (do_step) begin
         stride_in[k_ff - KW'(1)] = prod_in;
         k_in = k_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Stride datapath, rebuilt by the load and step states
   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
      k_ff      <= k_in;
      if (do_load) begin
         prod_ff <= ADDR_BITS'(1);
      end else if (do_step) begin
         prod_ff <= prod_in;
      end
   end

   assign geom.busy   = (state_ff != ST_IDLE);
   assign geom.rank   = rank_eff;
   assign geom.axis   = axis_s[AXIS_W-1:0];
   assign data_dims   = data_dims_ff;
   assign update_dims = update_dims_ff;
   assign stride      = stride_ff;

endmodule

// File: hdl/scatter_elements_address_gen.sv
// ----------------------------------------------------------------------------
// scatter_elements_address_gen
// Write-address generator for scatter-elements: one (index, value) word in,
// one store command (address, data, enable, error, last) out.
// ----------------------------------------------------------------------------
// Usage:
//   Feed update elements in row-major order of the update shape on the req_
//   channel; each accepted word yields exactly one rsp_ word in the same order.
//   req_restart zeroes the dimension counters before its own element.
//   The csr_ port writes rank, axis, data_dims and update_dims; the user must
//   make such writes only while the block is empty; the block does not enforce this.
//   Each write, and reset, rebuilds the strides, one multiply per cycle, with req_stall high.
// Pipeline and throughput:
//   Three register stages (coordinate, products, sum): the coordinate register
//   takes the accepted word, the products register follows, then the sum. One word per cycle
//   sustained while rsp_stall is low and no stride rebuild holds req_stall.
// Stall:
//   rsp_stall holds the output register; earlier stages keep filling bubbles
//   and req_stall rises only once every stage holds a word or a stride rebuild runs.
// Reset:
//   Synchronous, active high; clears counters and valid bits and resets the configuration registers.
// ----------------------------------------------------------------------------
`include "scatter_elements_address_gen_defines.svh"

module scatter_elements_address_gen
   import seag_pkg::*;
#(
   parameter int MAX_RANK  = 4,
   parameter int DIM_BITS  = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   // Input words
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IDX_W-1:0] req_index,
   input  logic [WORD_W-1:0]       req_value,
   input  logic                    req_restart,
   // Result words
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ADDR_OUT_W-1:0]   rsp_address,
   output logic [WORD_W-1:0]       rsp_data_word,
   output logic                    rsp_write_enable,
   output logic                    rsp_index_error,
   output logic                    rsp_last,
   // Configuration writes
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int KW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

   geom_type               geom;
   logic [CFG_W-1:0]       data_dims;
   logic [CFG_W-1:0]       update_dims;
   logic [ADDR_BITS-1:0]   stride [MAX_RANK];

   logic [MAX_DIM_W-1:0]   dfield [MAX_RANK];
   logic [MAX_DIM_W-1:0]   ufield [MAX_RANK];
   logic [DIM_BITS-1:0]    dsize  [MAX_RANK];
   logic [DIM_BITS-1:0]    usize  [MAX_RANK];

   // Stage enables
   logic accept;
   logic s1_en;
   logic s2_en;
   logic s3_en;

   // Counters and front-end logic
   logic [DIM_BITS-1:0]    cnt_ff [MAX_RANK];
   logic [DIM_BITS-1:0]    cnt_in [MAX_RANK];
   logic [DIM_BITS-1:0]    base   [MAX_RANK];
   logic [DIM_BITS-1:0]    inc    [MAX_RANK];
   logic [DIM_BITS-1:0]    cnt_nx [MAX_RANK];
   logic                   carry;
   logic [KW-1:0]          axis_k;
   logic [DIM_BITS-1:0]    asize;
   logic signed [IDX_W:0]  idx_x;
   logic signed [IDX_W:0]  size_x;
   logic signed [IDX_W:0]  pos_x;

   // Stage 1: coordinates
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [DIM_BITS-1:0]    s1_coord_ff [MAX_RANK];
   logic [DIM_BITS-1:0]    s1_coord_in [MAX_RANK];
   logic                   s1_err_ff;
   logic                   s1_err_in;
   logic                   s1_last_ff;
   logic                   s1_last_in;
   logic [WORD_W-1:0]      s1_value_ff;

   // Stage 2: products
   logic                   s2_valid_ff;
   logic [ADDR_BITS-1:0]   s2_prod_ff [MAX_RANK];
   logic [ADDR_BITS-1:0]   s2_prod_in [MAX_RANK];
   logic [DIM_BITS+ADDR_BITS-1:0] prod_full [MAX_RANK];
   logic                   s2_err_ff;
   logic                   s2_last_ff;
   logic [WORD_W-1:0]      s2_value_ff;

   // Stage 3: result register
   logic                   rsp_valid_ff;
   logic [ADDR_BITS-1:0]   sum;
   logic [ADDR_OUT_W-1:0]  addr_out;
   logic [ADDR_OUT_W-1:0]  rsp_address_ff;
   logic [ADDR_OUT_W-1:0]  rsp_address_in;
   logic [WORD_W-1:0]      rsp_data_word_ff;
   logic                   rsp_write_enable_ff;
   logic                   rsp_index_error_ff;
   logic                   rsp_last_ff;

   seag_cfg_regs #(
      .MAX_RANK  (MAX_RANK),
      .DIM_BITS  (DIM_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .geom             (geom),
      .data_dims        (data_dims),
      .update_dims      (update_dims),
      .stride           (stride)
   );

   // Unpack shapes; an update size of zero counts as one
   for (genvar g = 0; g < MAX_RANK; g++) begin : g_sizes
      assign dfield[g] = dim_at(data_dims, (MAX_RANK - 1 - g) * DIM_BITS);
      assign ufield[g] = dim_at(update_dims, (MAX_RANK - 1 - g) * DIM_BITS);
      assign dsize[g]  = dfield[g][DIM_BITS-1:0];
      assign usize[g]  = (ufield[g][DIM_BITS-1:0] == '0) ? DIM_BITS'(1)
                                                         : ufield[g][DIM_BITS-1:0];
   end

   // Handshake: each stage advances when empty or when the next one moves
   assign s3_en     = !rsp_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en || geom.busy;
   assign accept    = req_valid && !req_stall;

   // Axis lookup and index range check
   assign axis_k = geom.axis[KW-1:0];
   assign asize  = dsize[axis_k];
   assign idx_x  = $signed({req_index[IDX_W-1], req_index});
   assign size_x = $signed({{(IDX_W + 1 - DIM_BITS){1'b0}}, asize});
   assign pos_x  = idx_x[IDX_W] ? (idx_x + size_x) : idx_x;
   assign s1_err_in = (idx_x < -size_x) || (idx_x >= size_x);

   // Counter advance with carry from the innermost dimension, and last flag
   always_comb begin
      carry      = 1'b1;
      s1_last_in = 1'b1;
      for (int i = MAX_RANK - 1; i >= 0; i--) begin
         base[i]   = req_restart ? '0 : cnt_ff[i];
         inc[i]    = base[i] + DIM_BITS'(1);
         cnt_nx[i] = base[i];
         if (RANK_W'(i) < geom.rank) begin
            if (base[i] != usize[i] - DIM_BITS'(1)) begin
               s1_last_in = 1'b0;
            end
            if (carry) begin
               if (inc[i] != '0 && inc[i] < usize[i]) begin
                  cnt_nx[i] = inc[i];
                  carry     = 1'b0;
               end else begin
                  cnt_nx[i] = '0;
               end
            end
         end
         s1_coord_in[i] = (KW'(i) == axis_k) ? pos_x[DIM_BITS-1:0] : base[i];
         cnt_in[i]      = accept ? cnt_nx[i] : cnt_ff[i];
      end
   end

   assign s1_valid_in = s1_en ? accept : s1_valid_ff;

   // Products, dropped for unused dimensions
   for (genvar g = 0; g < MAX_RANK; g++) begin : g_prod
      assign prod_full[g]  = {{ADDR_BITS{1'b0}}, s1_coord_ff[g]}
                           * {{DIM_BITS{1'b0}}, stride[g]};
      assign s2_prod_in[g] = (RANK_W'(g) < geom.rank) ? prod_full[g][ADDR_BITS-1:0] : '0;
   end

   // Sum of products modulo the address width
   always_comb begin
      sum = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         sum = sum + s2_prod_ff[i];
      end
   end

   if (ADDR_BITS >= ADDR_OUT_W) begin : g_addr_trunc
      assign addr_out = sum[ADDR_OUT_W-1:0];
   end else begin : g_addr_ext
      assign addr_out = {{(ADDR_OUT_W - ADDR_BITS){1'b0}}, sum};
   end

   assign rsp_address_in = s2_err_ff ? '0 : addr_out;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '{default: '0};
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage payloads: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_coord_ff <= s1_coord_in;
         s1_err_ff   <= s1_err_in;
         s1_last_ff  <= s1_last_in;
         s1_value_ff <= req_value;
      end
      if (s2_en && s1_valid_ff) begin
         s2_prod_ff  <= s2_prod_in;
         s2_err_ff   <= s1_err_ff;
         s2_last_ff  <= s1_last_ff;
         s2_value_ff <= s1_value_ff;
      end
      if (s3_en && s2_valid_ff) begin
         rsp_address_ff      <= rsp_address_in;
         rsp_data_word_ff    <= s2_value_ff;
         rsp_write_enable_ff <= !s2_err_ff;
         rsp_index_error_ff  <= s2_err_ff;
         rsp_last_ff         <= s2_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address      = rsp_address_ff;
   assign rsp_data_word    = rsp_data_word_ff;
   assign rsp_write_enable = rsp_write_enable_ff;
   assign rsp_index_error  = rsp_index_error_ff;
   assign rsp_last         = rsp_last_ff;

   // Checks
   `SEAG_ASSERT_NXT(a_cfg_rebuild, csr_write_enable, geom.busy, "strides not rebuilt after write")
   `SEAG_ASSERT_IMP(a_err_no_store, rsp_valid_ff && rsp_index_error_ff, !rsp_write_enable_ff && rsp_address_ff == '0, "index error word carries a store")
   `SEAG_ASSERT_NXT(a_accept_fill, accept, s1_valid_ff, "accepted word lost at first stage")
   `SEAG_ASSERT_NXT(a_s1_hold, s1_valid_ff && !s2_en, s1_valid_ff && $stable(s1_value_ff), "blocked first stage changed")

endmodule

// File: verif/scatter_elements_address_gen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_elements_address_gen_tb
// Drives index/value words through the scatter write-address generator under
// random gaps and stalls, predicts every store command from its own model of
// the dimension counters and strides, and compares each result word in order.
// ----------------------------------------------------------------------------
module scatter_elements_address_gen_tb;
   import seag_pkg::*;

   localparam int MAX_DIMS       = 4;
   localparam int DIM_W          = 16;
   localparam int HALF_PERIOD    = 6;
   localparam int GAP_MAX        = 13;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SWEEP_CAP      = 200;
   localparam int REPORT_MAX     = 10;

   typedef struct packed {
      logic [ADDR_OUT_W-1:0] address;
      logic [WORD_W-1:0]     data_word;
      logic                  write_enable;
      logic                  index_error;
      logic                  last;
   } store_cmd_type;

   // Tracks register state and dimension counters, queues predicted stores
   class store_cmd_tracker;
      logic [RANK_CFG_W-1:0] rank_reg;
      logic [AXIS_W-1:0]     axis_reg;
      logic [CFG_W-1:0]      data_dims;
      logic [CFG_W-1:0]      update_dims;
      logic [DIM_W-1:0]      pos_count[MAX_DIMS];
      logic [31:0]           dim_stride[MAX_DIMS];
      store_cmd_type         pending_stores[$];
      int                    mismatches;

      function new();
         rank_reg    = RANK_RESET;
         axis_reg    = AXIS_RESET;
         data_dims   = DIMS_RESET;
         update_dims = DIMS_RESET;
         mismatches  = 0;
         foreach (pos_count[i]) pos_count[i] = '0;
         rebuild_strides();
      endfunction

      function int active_rank();
         int r;
         r = rank_reg;
         if (r < 1) r = 1;
         if (r > MAX_DIMS) r = MAX_DIMS;
         return r;
      endfunction

      // Wrap a negative axis, then clamp into the active dimensions
      function int active_axis();
         int r;
         int a;
         r = active_rank();
         a = $signed(axis_reg);
         if (a < 0) a += r;
         if (a < 0) a = 0;
         if (a >= r) a = r - 1;
         return a;
      endfunction

      function logic [DIM_W-1:0] dim_size(input logic [CFG_W-1:0] dims, input int i);
         return dims[(MAX_DIMS-1-i)*DIM_W +: DIM_W];
      endfunction

      function int upd_size(input int i);
         int s;
         s = dim_size(update_dims, i);
         return (s == 0) ? 1 : s;
      endfunction

      function int axis_size();
         return dim_size(data_dims, active_axis());
      endfunction

      // Elements in one full pass over the update shape, capped
      function int sweep_length();
         longint n;
         n = 1;
         for (int i = 0; i < active_rank(); i++) n = n * upd_size(i);
         return (n > SWEEP_CAP) ? SWEEP_CAP : int'(n);
      endfunction

      // Row-major strides of the data shape, modulo 2^32
      function void rebuild_strides();
         int r;
         r = active_rank();
         foreach (dim_stride[i]) dim_stride[i] = '0;
         dim_stride[r-1] = 1;
         for (int i = r - 1; i > 0; i--)
            dim_stride[i-1] = dim_size(data_dims, i) * dim_stride[i];
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
         case (idx)
            CSR_RANK: begin
               rank_reg = data[RANK_CFG_W-1:0];
            end
            CSR_AXIS: begin
               axis_reg = data[AXIS_W-1:0];
            end
            CSR_DATA_DIMS: begin
               data_dims = data;
            end
            CSR_UPDATE_DIMS: begin
               update_dims = data;
            end
            default: begin
            end
         endcase
         rebuild_strides();
      endfunction

      // Predict the store for one accepted word, then advance the counters
      function void note_word(input logic signed [IDX_W-1:0] index,
                              input logic [WORD_W-1:0] value, input logic restart);
         int               r;
         int               ax;
         int               idx;
         int               size;
         int               pos;
         logic [31:0]      coord;
         logic [31:0]      addr;
         logic [DIM_W-1:0] nxt;
         store_cmd_type    cmd;
         r    = active_rank();
         ax   = active_axis();
         idx  = index;
         size = axis_size();
         if (restart) begin
            foreach (pos_count[i]) pos_count[i] = '0;
         end
         cmd.index_error = (idx < -size) || (idx >= size);
         addr = '0;
         if (!cmd.index_error) begin
            pos = (idx < 0) ? idx + size : idx;
            for (int i = 0; i < r; i++) begin
               coord = (i == ax) ? pos : pos_count[i];
               addr  = addr + coord * dim_stride[i];
            end
         end
         cmd.last = 1'b1;
         for (int i = 0; i < r; i++) begin
            if (pos_count[i] != upd_size(i) - 1) cmd.last = 1'b0;
         end
         cmd.address      = addr;
         cmd.data_word    = value;
         cmd.write_enable = !cmd.index_error;
         pending_stores   = {pending_stores, cmd};
         // ripple carry from the innermost dimension
         for (int i = r - 1; i >= 0; i--) begin
            nxt = pos_count[i] + 16'd1;
            if (nxt != 0 && nxt < upd_size(i)) begin
               pos_count[i] = nxt;
               break;
            end
            pos_count[i] = '0;
         end
      endfunction

      function void flag(input string msg);
         mismatches++;
         if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
      endfunction

      function void check_store(input logic [ADDR_OUT_W-1:0] address,
                                input logic [WORD_W-1:0] data_word, input logic write_enable,
                                input logic index_error, input logic last);
         store_cmd_type want;
         store_cmd_type got;
         got = '{address, data_word, write_enable, index_error, last};
         if (pending_stores.size() == 0) begin
            flag($sformatf("unexpected store: addr %h data %h we %b err %b last %b",
                           address, data_word, write_enable, index_error, last));
            return;
         end
         want = pending_stores.pop_front();
         if (got !== want)
            flag($sformatf({"store mismatch: expected addr %h data %h we %b err %b last %b,",
                            " got addr %h data %h we %b err %b last %b"},
                           want.address, want.data_word, want.write_enable,
                           want.index_error, want.last, address, data_word,
                           write_enable, index_error, last));
      endfunction

      function int pending();
         return pending_stores.size();
      endfunction

      // Flag predicted stores that never showed up and return the mismatch count
      function int finish_check();
         store_cmd_type want;
         while (pending_stores.size() != 0) begin
            want = pending_stores.pop_front();
            flag($sformatf("missing store: addr %h data %h", want.address, want.data_word));
         end
         return mismatches;
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [IDX_W-1:0]      req_index        = '0;
   logic [WORD_W-1:0]     req_value        = '0;
   logic                  req_restart      = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [ADDR_OUT_W-1:0] rsp_address;
   logic [WORD_W-1:0]     rsp_data_word;
   logic                  rsp_write_enable;
   logic                  rsp_index_error;
   logic                  rsp_last;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_RANK;
   logic [CFG_W-1:0]      csr_wdata        = '0;

   int req_gap_max = GAP_MAX;
   int rsp_gap_max = GAP_MAX;
   int rsp_hold    = 0;
   int idle_cycles = 0;

   store_cmd_tracker store_check = new();

   scatter_elements_address_gen u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_index        (req_index),
      .req_value        (req_value),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_address      (rsp_address),
      .rsp_data_word    (rsp_data_word),
      .rsp_write_enable (rsp_write_enable),
      .rsp_index_error  (rsp_index_error),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Offer one word after a random gap and hold it until accepted
   task automatic send_word(input logic [IDX_W-1:0] index, input logic [WORD_W-1:0] value,
                            input logic restart);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_index   = index;
      req_value   = value;
      req_restart = restart;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      store_check.note_word(index, value, restart);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (store_check.pending() != 0) @(posedge clock);
   endtask

   // Write one register once the stride rebuild has finished
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_wdata        = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      store_check.write_reg(idx, data);
   endtask

   task automatic set_config(input logic [RANK_CFG_W-1:0] rank, input logic [AXIS_W-1:0] axis,
                             input logic [CFG_W-1:0] ddims, input logic [CFG_W-1:0] udims);
      wait_drained();
      write_csr(CSR_RANK, CFG_W'(rank));
      write_csr(CSR_AXIS, CFG_W'(axis));
      write_csr(CSR_DATA_DIMS, ddims);
      write_csr(CSR_UPDATE_DIMS, udims);
   endtask

   // Mostly in-range indexes, with edges and raw 17-bit noise
   function automatic logic [IDX_W-1:0] pick_index(input int size);
      int               choice;
      logic [IDX_W-1:0] v;
      choice = $urandom_range(0, 19);
      if (size == 0 || choice < 3) v = $urandom;
      else if (choice == 3) v = size;
      else if (choice == 4) v = -size - 1;
      else v = $urandom_range(0, 2 * size - 1) - size;
      return v;
   endfunction

   function automatic logic [CFG_W-1:0] random_dims(input bit is_update);
      logic [CFG_W-1:0] dims;
      int               pick;
      for (int i = 0; i < MAX_DIMS; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) dims[i*DIM_W +: DIM_W] = '0;
         else if (is_update) dims[i*DIM_W +: DIM_W] = $urandom_range(1, 3);
         else if (pick == 1) dims[i*DIM_W +: DIM_W] = '1;
         else if (pick == 2) dims[i*DIM_W +: DIM_W] = $urandom;
         else dims[i*DIM_W +: DIM_W] = $urandom_range(1, 9);
      end
      return dims;
   endfunction

   // Stream passes over the update shape; some cut short, some restarted early
   task automatic run_items(input int n_items, input bit restart_first);
      int sent;
      int sweep;
      bit rst;
      sent = 0;
      while (sent < n_items) begin
         sweep = store_check.sweep_length();
         if ($urandom_range(0, 9) == 0) sweep = $urandom_range(1, sweep);
         for (int k = 0; k < sweep && sent < n_items; k++) begin
            if (k == 0) rst = (sent == 0) ? restart_first : ($urandom_range(0, 5) != 0);
            else rst = ($urandom_range(0, 49) == 0);
            send_word(pick_index(store_check.axis_size()), $urandom, rst);
            sent++;
         end
      end
      req_valid = 1'b0;
   endtask

   // Result side: random stall per word, or one long hold-off when asked
   initial begin
      int hold;
      forever begin
         if (rsp_hold > 0) begin
            hold     = rsp_hold;
            rsp_hold = 0;
         end else begin
            hold = $urandom_range(0, rsp_gap_max);
         end
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
         @(negedge clock);
      end
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         store_check.check_store(rsp_address, rsp_data_word, rsp_write_enable,
                                 rsp_index_error, rsp_last);
   end

   // Abort when no word moves on either side for too long
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** scatter_elements_address_gen: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // reset shape: rank 1, size 1, so only index 0 and -1 are legal
      send_word(17'h00000, 32'h0000_0000, 1'b1);
      send_word(17'h1FFFF, 32'hFFFF_FFFF, 1'b0);
      send_word(17'h00001, 32'hA5A5_A5A5, 1'b0);
      send_word(17'h0FFFF, 32'h5A5A_5A5A, 1'b0);
      send_word(17'h10000, 32'h8000_0001, 1'b0);
      send_word(17'h10001, 32'h0000_0001, 1'b1);
      req_valid = 1'b0;

      // full-size axes, strides wrap past 32 bits, zero update sizes
      set_config(3'd4, 3'b100, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_word(17'h0FFFE, 32'h1234_5678, 1'b1);
      send_word(17'h10001, 32'h8765_4321, 1'b0);
      send_word(17'h0FFFF, 32'hDEAD_BEEF, 1'b0);
      send_word(17'h10000, 32'hCAFE_F00D, 1'b0);
      req_valid = 1'b0;

      // rank 0 acts as 1, axis beyond rank clamps to 0
      set_config(3'd0, 3'b011, 64'h0002_0003_0004_0005, 64'h0003_0002_0002_0002);
      send_word(17'h00001, 32'h0000_0011, 1'b1);
      send_word(17'h1FFFE, 32'h0000_0022, 1'b0);
      send_word(17'h00000, 32'h0000_0033, 1'b0);
      send_word(17'h00001, 32'h0000_0044, 1'b0);
      req_valid = 1'b0;

      // rank above max clamps, axis -1 is the innermost dimension
      set_config(3'd7, 3'b111, 64'h0002_0003_0005_0004, 64'h0002_0001_0000_0003);
      send_word(17'h00003, 32'h0000_0101, 1'b1);
      send_word(17'h1FFFC, 32'h0000_0102, 1'b0);
      send_word(17'h00000, 32'h0000_0103, 1'b0);
      send_word(17'h1FFFF, 32'h0000_0104, 1'b0);
      send_word(17'h00002, 32'h0000_0105, 1'b0);
      send_word(17'h00001, 32'h0000_0106, 1'b0);
      send_word(17'h00004, 32'h0000_0107, 1'b0);
      req_valid = 1'b0;

      // zero-size axis: every index is out of range
      set_config(3'd2, 3'b110, 64'h0, 64'h0004_0004_0000_0000);
      send_word(17'h00000, 32'h0000_0201, 1'b1);
      send_word(17'h1FFFF, 32'h0000_0202, 1'b0);
      send_word(17'h00001, 32'h0000_0203, 1'b0);
      req_valid = 1'b0;

      // random shapes; one phase holds the result side off to back up the pipe
      for (int phase = 0; phase < 12; phase++) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
         if (phase == 2) begin
            req_gap_max = 0;
            rsp_hold    = HOLD_CYCLES;
         end
         set_config($urandom_range(0, 7), $urandom_range(0, 7), random_dims(1'b0),
                    random_dims(1'b1));
         run_items(56, $urandom_range(0, 3) != 0);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (store_check.finish_check() == 0) begin
         $display("** scatter_elements_address_gen: PASSED **");
      end else begin
         $display("** scatter_elements_address_gen: FAILED **");
      end
      $finish;
   end

endmodule
